// ===== sv/alist_pkg.sv =====
package alist_pkg;

  // list geometry
  localparam int unsigned DEPTH     = 16;
  localparam int unsigned VAL_W     = 8;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned ST_W      = 2;
  localparam int unsigned FIDX_W    = 4;
  localparam int unsigned CNT_OUT_W = 5;

  // internal widths follow the depth and the position width
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [OP_W-1:0] {
    OP_READ      = 3'd0,
    OP_SEARCH    = 3'd1,
    OP_APPEND    = 3'd2,
    OP_INSERT    = 3'd3,
    OP_OVERWRITE = 3'd4,
    OP_REMOVE    = 3'd5
  } alist_op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOTFOUND = 2'd3
  } alist_status_e;

  // per-cycle command broadcast along the cell row
  typedef struct packed {
    logic             ins;
    logic             wr;
    logic             del;
    logic [CMP_W-1:0] pos;
    logic [CMP_W-1:0] used;
    logic [VAL_W-1:0] val;
  } alist_ctrl_t;

endpackage

// ===== sv/alist_req_if.sv =====
interface alist_req_if import alist_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink   (input valid, input op, input position, input value, output ready);
endinterface

// ===== sv/alist_rsp_if.sv =====
interface alist_rsp_if import alist_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ST_W-1:0]      status;
  logic [VAL_W-1:0]     read_data;
  logic [FIDX_W-1:0]    found_index;
  logic [CNT_OUT_W-1:0] count;

  modport source (output valid, output status, output read_data, output found_index,
                  output count, input ready);
  modport sink   (input valid, input status, input read_data, input found_index,
                  input count, output ready);
endinterface

// ===== sv/array_list_engine.sv =====
// channel  dir  handshake       payload
// req_i    in   valid / ready   op, position, value
// rsp_o    out  valid / ready   status, read_data, found_index, count
//
// one request per cycle while responses are taken; its response appears in the output register the
// cycle after acceptance, all list cells shift or load in that same edge
// a new request is taken while the held response is being taken
// rst_ni clears the entry count and the response valid flag; entry cells
// are not reset and are only read below the count
// a stalled response holds its register and blocks further requests
module array_list_engine import alist_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  alist_req_if.sink   req_i,
  alist_rsp_if.source rsp_o
);

  logic [CNT_W-1:0]     used_q, used_d;
  logic                 rsp_valid_q;
  logic [ST_W-1:0]      status_q;
  logic [VAL_W-1:0]     rdata_q;
  logic [FIDX_W-1:0]    fidx_q;
  logic [CNT_OUT_W-1:0] count_q;

  logic                 accept;
  alist_op_e            op;
  alist_status_e        status;
  alist_ctrl_t          ctrl;
  logic [CMP_W-1:0]     pos_x, used_x;
  logic                 full, in_rng;
  logic [VAL_W-1:0]     rdata, rd_or;
  logic [CMP_W-1:0]     fidx;
  logic [DEPTH-1:0]     hit, first;
  logic [VAL_W-1:0]     cell_data [DEPTH];
  logic [VAL_W-1:0]     cell_rd   [DEPTH];

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign op          = alist_op_e'(req_i.op);
  assign pos_x       = CMP_W'(req_i.position);
  assign used_x      = CMP_W'(used_q);
  assign full        = (used_q == CNT_W'(DEPTH));
  assign in_rng      = (pos_x < used_x);

  // command to the cell row and next entry count
  always_comb begin
    used_d    = used_q;
    ctrl.ins  = 1'b0;
    ctrl.wr   = 1'b0;
    ctrl.del  = 1'b0;
    ctrl.pos  = pos_x;
    ctrl.used = used_x;
    ctrl.val  = req_i.value;
    unique case (op)
      OP_APPEND: begin
        ctrl.pos = used_x;
        if (!full) begin
          ctrl.ins = accept;
          used_d   = used_q + CNT_W'(1);
        end
      end
      OP_INSERT: begin
        if (!full && (pos_x <= used_x)) begin
          ctrl.ins = accept;
          used_d   = used_q + CNT_W'(1);
        end
      end
      OP_OVERWRITE: begin
        if (in_rng) begin
          ctrl.wr = accept;
        end
      end
      OP_REMOVE: begin
        if (in_rng) begin
          ctrl.del = accept;
          used_d   = used_q - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // request decode into status and read data
  always_comb begin
    status = ST_OK;
    rdata  = '0;
    unique case (op)
      OP_READ: begin
        if (in_rng) begin
          rdata = rd_or;
        end else begin
          status = ST_RANGE;
        end
      end
      OP_SEARCH: begin
        status = (|hit) ? ST_OK : ST_NOTFOUND;
      end
      OP_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end
      end
      OP_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else if (pos_x > used_x) begin
          status = ST_RANGE;
        end
      end
      OP_OVERWRITE: begin
        if (!in_rng) begin
          status = ST_RANGE;
        end
      end
      OP_REMOVE: begin
        if (!in_rng) begin
          status = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  // row of list cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] lower, upper;
    if (i == 0) begin : g_lo
      assign lower = '0;
    end else begin : g_lo
      assign lower = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi
      assign upper = '0;
    end else begin : g_hi
      assign upper = cell_data[i+1];
    end
    alist_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (CMP_W'(i)),
      .lower_i (lower),
      .upper_i (upper),
      .data_o  (cell_data[i]),
      .hit_o   (hit[i]),
      .rd_o    (cell_rd[i])
    );
  end

  // lowest matching cell, then encode its index; read taps are one-hot
  assign first = hit & (~hit + DEPTH'(1));

  always_comb begin
    fidx  = '0;
    rd_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      fidx  = fidx | (first[i] ? CMP_W'(i) : '0);
      rd_or = rd_or | cell_rd[i];
    end
  end

  // list count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (accept) begin
      used_q <= used_d;
    end
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (accept) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status;
      rdata_q  <= rdata;
      fidx_q   <= (op == OP_SEARCH && status == ST_OK) ? FIDX_W'(fidx) : '0;
      count_q  <= CNT_OUT_W'(used_d);
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.read_data   = rdata_q;
  assign rsp_o.found_index = fidx_q;
  assign rsp_o.count       = count_q;

  // checks
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> rsp_valid_q)
    else $error("accepted request gave no response");

  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(used_q))
    else $error("count moved without a request");

  a_full_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && status_q == ST_FULL) |-> full)
    else $error("full status while list not full");

endmodule

// ===== sv/alist_cell.sv =====
module alist_cell import alist_pkg::*; (
  input  logic             clk_i,
  input  alist_ctrl_t      ctrl_i,
  input  logic [CMP_W-1:0] idx_i,
  input  logic [VAL_W-1:0] lower_i,
  input  logic [VAL_W-1:0] upper_i,
  output logic [VAL_W-1:0] data_o,
  output logic             hit_o,
  output logic [VAL_W-1:0] rd_o
);

  logic [VAL_W-1:0] data_q, data_d;

  // next entry: shift up on insert, shift down on remove, or load the value
  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (idx_i > ctrl_i.pos) begin
        data_d = lower_i;
      end else if (idx_i == ctrl_i.pos) begin
        data_d = ctrl_i.val;
      end
    end else if (ctrl_i.wr) begin
      if (idx_i == ctrl_i.pos) begin
        data_d = ctrl_i.val;
      end
    end else if (ctrl_i.del) begin
      if (idx_i >= ctrl_i.pos) begin
        data_d = upper_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // local compare and read tap
  assign data_o = data_q;
  assign hit_o  = (idx_i < ctrl_i.used) && (data_q == ctrl_i.val);
  assign rd_o   = (idx_i == ctrl_i.pos) ? data_q : '0;

endmodule

// ===== tb/sv/alist_response_check.sv =====
`timescale 1ns / 100ps

module alist_response_check import alist_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  alist_req_if        req_i,
  alist_rsp_if        rsp_i,
  output int unsigned err_cnt_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned full_cnt_o,
  output int unsigned range_cnt_o,
  output int unsigned miss_cnt_o
);

  typedef struct packed {
    alist_status_e        status;
    logic [VAL_W-1:0]     read_data;
    logic [FIDX_W-1:0]    found_index;
    logic [CNT_OUT_W-1:0] count;
  } list_rsp_t;

  // mirror of the list contents and length
  logic [VAL_W-1:0] mirror_list [DEPTH];
  int unsigned      mirror_len;
  list_rsp_t        due_rsp_q [$];

  int unsigned err_cnt;
  int unsigned checked_cnt;
  int unsigned full_cnt;
  int unsigned range_cnt;
  int unsigned miss_cnt;

  // carries out one request on the mirror and gives the response it should produce
  function automatic list_rsp_t apply_list_op(input logic [OP_W-1:0]  op,
                                              input logic [POS_W-1:0] pos,
                                              input logic [VAL_W-1:0] val);
    list_rsp_t   r;
    int unsigned i;
    r        = '0;
    r.status = ST_OK;
    case (op)
      OP_READ: begin
        if (pos < mirror_len) r.read_data = mirror_list[pos];
        else r.status = ST_RANGE;
      end
      OP_SEARCH: begin
        // every entry is searched, the last one included
        r.status = ST_NOTFOUND;
        for (i = 0; i < mirror_len; i++) begin
          if (mirror_list[i] == val) begin
            r.status      = ST_OK;
            r.found_index = i[FIDX_W-1:0];
            break;
          end
        end
      end
      OP_APPEND: begin
        if (mirror_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          mirror_list[mirror_len] = val;
          mirror_len++;
        end
      end
      OP_INSERT: begin
        // full check takes priority over the position check
        if (mirror_len >= DEPTH) begin
          r.status = ST_FULL;
        end else if (pos > mirror_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = mirror_len; i > pos; i--) mirror_list[i] = mirror_list[i-1];
          mirror_list[pos] = val;
          mirror_len++;
        end
      end
      OP_OVERWRITE: begin
        if (pos < mirror_len) mirror_list[pos] = val;
        else r.status = ST_RANGE;
      end
      OP_REMOVE: begin
        if (pos < mirror_len) begin
          for (i = pos; i + 1 < mirror_len; i++) mirror_list[i] = mirror_list[i+1];
          mirror_len--;
        end else begin
          r.status = ST_RANGE;
        end
      end
      default: ;
    endcase
    r.count = mirror_len[CNT_OUT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] response check: %s", $realtime, msg);
    err_cnt++;
  endtask

  // compare each taken response, then log the request taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    list_rsp_t want;
    if (!rst_ni) begin
      mirror_len = 0;
      due_rsp_q.delete();
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        checked_cnt++;
        case (rsp_i.status)
          ST_FULL:     full_cnt++;
          ST_RANGE:    range_cnt++;
          ST_NOTFOUND: miss_cnt++;
          default: ;
        endcase
        if (due_rsp_q.size() == 0) begin
          report_mismatch($sformatf("response %0d arrived with no request outstanding",
                                    checked_cnt));
        end else begin
          want = due_rsp_q.pop_front();
          if (rsp_i.status !== want.status)
            report_mismatch($sformatf("response %0d status %0d, expected %0d",
                                      checked_cnt, rsp_i.status, want.status));
          if (rsp_i.read_data !== want.read_data)
            report_mismatch($sformatf("response %0d read_data 0x%02h, expected 0x%02h",
                                      checked_cnt, rsp_i.read_data, want.read_data));
          if (rsp_i.found_index !== want.found_index)
            report_mismatch($sformatf("response %0d found_index %0d, expected %0d",
                                      checked_cnt, rsp_i.found_index, want.found_index));
          if (rsp_i.count !== want.count)
            report_mismatch($sformatf("response %0d count %0d, expected %0d",
                                      checked_cnt, rsp_i.count, want.count));
        end
      end
      if (req_i.valid && req_i.ready)
        due_rsp_q.push_back(apply_list_op(req_i.op, req_i.position, req_i.value));
    end
    err_cnt_o   <= err_cnt;
    pending_o   <= due_rsp_q.size();
    checked_o   <= checked_cnt;
    full_cnt_o  <= full_cnt;
    range_cnt_o <= range_cnt;
    miss_cnt_o  <= miss_cnt;
  end

endmodule

// ===== tb/sv/array_list_engine_tb.sv =====
`timescale 1ns / 100ps

module array_list_engine_tb;
  import alist_pkg::*;

  // codes the block leaves unused
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  localparam int unsigned RANDOM_REQS   = 800;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 10;

  localparam alist_op_e LIST_OPS [6] = '{OP_READ, OP_SEARCH, OP_APPEND,
                                         OP_INSERT, OP_OVERWRITE, OP_REMOVE};

  logic clk_i;
  logic rst_ni;

  alist_req_if req_if ();
  alist_rsp_if rsp_if ();

  int unsigned err_cnt;
  int unsigned pending;
  int unsigned checked;
  int unsigned full_cnt;
  int unsigned range_cnt;
  int unsigned miss_cnt;

  bit          gaps_on   = 1'b1;
  bit          stalls_on = 1'b1;
  int unsigned sent_cnt  = 0;
  int unsigned list_fill = 0;
  int unsigned cycle_cnt = 0;
  int unsigned seg_idx   = 0;
  int unsigned stop_at;

  array_list_engine u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  alist_response_check u_rsp_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_i       (rsp_if),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending),
    .checked_o   (checked),
    .full_cnt_o  (full_cnt),
    .range_cnt_o (range_cnt),
    .miss_cnt_o  (miss_cnt)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // response side back-pressure
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= !(stalls_on && $urandom_range(99) < 8);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles", cycle_cnt);
      $display("array_list_engine_tb: errors");
      $finish;
    end
  end

  // half the values come from a narrow pool so that searches hit
  function automatic logic [VAL_W-1:0] pick_val();
    if ($urandom_range(1) == 0) return VAL_W'($urandom_range(7));
    return VAL_W'($urandom_range(255));
  endfunction

  // mostly a position inside the list, sometimes anywhere
  function automatic logic [POS_W-1:0] pick_pos();
    if (list_fill == 0 || $urandom_range(5) == 0) return POS_W'($urandom_range(DEPTH-1));
    return POS_W'($urandom_range(list_fill - 1));
  endfunction

  // one request, with optional idle cycles ahead of it
  task automatic send_req(input logic [OP_W-1:0]  op,
                          input logic [POS_W-1:0] pos,
                          input logic [VAL_W-1:0] val);
    if (gaps_on) begin
      while ($urandom_range(99) < 8) begin
        req_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    req_if.valid    <= 1'b1;
    req_if.op       <= op;
    req_if.position <= pos;
    req_if.value    <= val;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sent_cnt++;
    // rough track of the list length, used only to shape stimulus
    case (op)
      OP_APPEND: if (list_fill < DEPTH) list_fill++;
      OP_INSERT: if (list_fill < DEPTH && pos <= list_fill) list_fill++;
      OP_REMOVE: if (pos < list_fill) list_fill--;
      default: ;
    endcase
  endtask

  // hold off new requests until every response is back
  task automatic drain_responses();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned n;
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.op       = '0;
    req_if.position = '0;
    req_if.value    = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list corners
    send_req(OP_READ, 4'd0, 8'h00);
    send_req(OP_REMOVE, 4'd0, 8'h00);
    send_req(OP_SEARCH, 4'd0, 8'h00);
    send_req(OP_OVERWRITE, 4'd0, 8'hFF);
    send_req(OP_INSERT, 4'd1, 8'h11);
    // building a short list, insert at the end acts as an append
    send_req(OP_INSERT, 4'd0, 8'hFF);
    send_req(OP_APPEND, 4'd15, 8'h00);
    send_req(OP_INSERT, 4'd2, 8'hA5);
    send_req(OP_INSERT, 4'd1, 8'h3C);
    // match on the last entry, then a miss
    send_req(OP_SEARCH, 4'd0, 8'hA5);
    send_req(OP_SEARCH, 4'd9, 8'h77);
    send_req(OP_READ, 4'd3, 8'h00);
    send_req(OP_READ, 4'd15, 8'h00);
    send_req(OP_OVERWRITE, 4'd0, 8'h5A);
    send_req(OP_OVERWRITE, 4'd4, 8'h01);
    send_req(OP_REMOVE, 4'd1, 8'h00);
    send_req(OP_REMOVE, 4'd3, 8'h00);
    send_req(OP_READ, 4'd2, 8'h00);
    send_req(OP_SPARE_A, 4'd15, 8'hFF);
    send_req(OP_SPARE_B, 4'd0, 8'h00);
    drain_responses();

    // random: fill, drain, mixed access and noise segments
    stop_at = sent_cnt + RANDOM_REQS;
    while (sent_cnt < stop_at) begin
      seg_idx++;
      gaps_on   = !(seg_idx >= 8 && seg_idx < 14);
      stalls_on = gaps_on;
      case ($urandom_range(3))
        0: begin
          n = DEPTH - list_fill + $urandom_range(1, 3);
          repeat (n) begin
            if ($urandom_range(1) == 0)
              send_req(OP_APPEND, POS_W'($urandom_range(DEPTH-1)), pick_val());
            else
              send_req(OP_INSERT,
                       POS_W'($urandom_range(list_fill < DEPTH ? list_fill : DEPTH-1)),
                       pick_val());
          end
        end
        1: begin
          n = list_fill + $urandom_range(1, 3);
          repeat (n) send_req(OP_REMOVE, pick_pos(), pick_val());
        end
        2: begin
          repeat (24) send_req(LIST_OPS[$urandom_range(5)], pick_pos(), pick_val());
        end
        default: begin
          repeat (8) send_req(OP_W'($urandom_range(7)), POS_W'($urandom_range(15)),
                              VAL_W'($urandom_range(255)));
        end
      endcase
      if ($urandom_range(7) == 0) drain_responses();
    end

    // wind down
    drain_responses();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("sent %0d requests over %0d segments, %0d responses compared",
             sent_cnt, seg_idx, checked);
    $display("status mix seen: %0d full, %0d out of range, %0d not found",
             full_cnt, range_cnt, miss_cnt);
    if (err_cnt == 0 && pending == 0) begin
      $display("array_list_engine_tb: clean");
    end else begin
      $display("array_list_engine_tb: errors");
    end
    $finish;
  end

endmodule

// ===== array_list_engine.f =====
sv/alist_pkg.sv
sv/alist_req_if.sv
sv/alist_rsp_if.sv
sv/alist_cell.sv
sv/array_list_engine.sv
tb/sv/alist_response_check.sv
tb/sv/array_list_engine_tb.sv
